// File: rtl/assert_macros.svh
// Assertion macros for the error statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/res_pkg.sv
// ----------------------------------------------------------------------------
// res_pkg
// Shared widths and types for the running error statistics core.
// ----------------------------------------------------------------------------
package res_pkg;
  localparam int COUNT_BITS_DEF = 32;
  localparam int CNT_W = 32;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W = 17;
  localparam int SQ_W = 31;
  localparam int ABS_SUM_W = 48;
  localparam int SQ_SUM_W = 61;
  localparam int MEAN_W = 16;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [MAG_W-1:0]     mag;
  } cmd_t;
endpackage

// File: rtl/res_front.sv
// ----------------------------------------------------------------------------
// res_front
// Accept words, classify them and form the sample magnitude; two-entry queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module res_front import res_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic signed [SAMPLE_W-1:0] in_error_sample,
  output logic                q_valid,
  input  logic                q_ready,
  output cmd_t                q_cmd
);
  cmd_t q_r [2];
  cmd_t q_nxt;
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    q_nxt.kind = in_kind;
    if (in_kind == KIND_CLEAR) q_nxt.mag = '0;
    else if (in_error_sample[SAMPLE_W-1])
      q_nxt.mag = MAG_W'(-$signed({in_error_sample[SAMPLE_W-1], in_error_sample}));
    else q_nxt.mag = {1'b0, in_error_sample};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) q_r[wp_r] <= q_nxt;
  end

  `ASSERT_IMPL(a_cnt_max, clk, rst_n, cnt_r != 2'd3, "queue count out of range")
  `ASSERT_NEXT(a_full_hold, clk, rst_n, cnt_r == 2'd2 && !pop, cnt_r == 2'd2,
    "full queue lost entry")
  `ASSERT_NEXT(a_empty_hold, clk, rst_n, cnt_r == 2'd0 && !push, cnt_r == 2'd0,
    "empty queue gained entry")
endmodule

// File: rtl/res_back.sv
// ----------------------------------------------------------------------------
// res_back
// Update count and sums; if nonzero, run two restoring divisions and a square root.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module res_back import res_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  cmd_t              q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  out_sample_count,
  output logic [MEAN_W-1:0] out_mean_abs_error,
  output logic [MEAN_W-1:0] out_rms_error
);
  localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV1 = 3'd1, ST_DIV2 = 3'd2,
                         ST_SQRT = 3'd3, ST_DONE = 3'd4, ST_DIV3 = 3'd5;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam int DW = 64;

  logic [2:0] st_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [ABS_SUM_W-1:0] abs_r;
  logic [SQ_SUM_W-1:0] sq_r;
  logic [DW-1:0] num_r, quo_r;
  logic [DW:0] rem_r;
  logic [6:0] it_r;
  logic [DW-1:0] ms_r;
  logic [31:0] root_r;
  logic [DW+1:0] srem_r;
  logic [MEAN_W-1:0] mae_r;
  logic out_valid_r;
  logic [CNT_W-1:0] oc_r;
  logic [MEAN_W-1:0] om_r, or_r;

  logic [DW:0] rem_sh, rem_sub;
  logic [DW+1:0] sr_sh, sr_trial;
  logic [ABS_SUM_W:0] abs_add;
  logic [SQ_SUM_W:0] sq_add;
  logic [SQ_W-1:0] sq_mag;
  logic [DW-1:0] mae_q;
  logic done_fire;

  assign sq_mag = SQ_W'(q_cmd.mag * q_cmd.mag);
  assign abs_add = {1'b0, abs_r} + (ABS_SUM_W+1)'(q_cmd.mag);
  assign sq_add = {1'b0, sq_r} + (SQ_SUM_W+1)'(sq_mag);
  assign rem_sh = {rem_r[DW-1:0], num_r[DW-1]};
  assign rem_sub = rem_sh - (DW+1)'(count_r);
  assign sr_sh = {srem_r[DW-1:0], ms_r[DW-1:DW-2]};
  assign sr_trial = sr_sh - (DW+2)'({root_r, 2'b01});
  assign mae_q = rem_sub[DW] ? {quo_r[DW-2:0], 1'b0} : {quo_r[DW-2:0], 1'b1};
  assign done_fire = (st_r == ST_DONE) && (!out_valid_r || out_ready);

  assign q_ready = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_sample_count = oc_r;
  assign out_mean_abs_error = om_r;
  assign out_rms_error = or_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= '0;
      abs_r <= '0;
      sq_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (done_fire) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (q_valid) begin
          if (q_cmd.kind == KIND_CLEAR) begin
            count_r <= '0;
            abs_r <= '0;
            sq_r <= '0;
          end else if (count_r != CNT_MAX) begin
            count_r <= count_r + 1'b1;
            abs_r <= abs_add[ABS_SUM_W] ? '1 : abs_add[ABS_SUM_W-1:0];
            sq_r <= sq_add[SQ_SUM_W] ? '1 : sq_add[SQ_SUM_W-1:0];
          end
          st_r <= ST_DIV1;
        end
        ST_DIV1: begin
          num_r <= DW'(abs_r) + DW'(count_r >> 1);
          rem_r <= '0;
          quo_r <= '0;
          it_r <= '0;
          st_r <= (count_r == '0) ? ST_DONE : ST_DIV2;
          mae_r <= '0;
        end
        ST_DIV2, ST_DIV3: begin
          num_r <= {num_r[DW-2:0], 1'b0};
          rem_r <= rem_sub[DW] ? rem_sh : rem_sub;
          quo_r <= mae_q;
          it_r <= it_r + 1'b1;
          if (it_r == 7'(DW-1)) begin
            it_r <= '0;
            if (st_r == ST_DIV2) begin
              mae_r <= (mae_q > DW'(16'hFFFF)) ? '1 : MEAN_W'(mae_q);
              num_r <= DW'(sq_r);
              rem_r <= '0;
              quo_r <= '0;
              st_r <= ST_DIV3;
            end else begin
              ms_r <= mae_q;
              srem_r <= '0;
              root_r <= '0;
              st_r <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          ms_r <= {ms_r[DW-3:0], 2'b00};
          srem_r <= sr_trial[DW+1] ? sr_sh : sr_trial;
          root_r <= {root_r[30:0], ~sr_trial[DW+1]};
          it_r <= it_r + 1'b1;
          if (it_r == 7'd31) st_r <= ST_DONE;
        end
        ST_DONE: if (done_fire) begin
          oc_r <= CNT_W'(count_r);
          om_r <= mae_r;
          if (count_r == '0) or_r <= '0;
          else if ((srem_r[DW:0] > {33'd0, root_r}) && root_r < 32'hFFFF)
            or_r <= MEAN_W'(root_r + 1'b1);
          else or_r <= (root_r > 32'hFFFF) ? '1 : MEAN_W'(root_r);
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_cnt_rng, clk, rst_n, !out_valid_r || oc_r <= CNT_W'(CNT_MAX),
    "count above limit")
  `ASSERT_NEXT(a_done_to_idle, clk, rst_n, done_fire,
    out_valid_r && st_r == ST_IDLE, "result not issued")
  `ASSERT_IMPL(a_ready_idle, clk, rst_n, q_ready == (st_r == ST_IDLE),
    "ready outside idle")
endmodule

// File: rtl/running_error_statistics_core.sv
// ----------------------------------------------------------------------------
// running_error_statistics_core
// Running MAE and RMS error accumulator over Q2.14 error samples.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in      | input     | kind, error_sample
// out     | output    | sample_count, mean_abs_error, rms_error
// A sample word passes through the queue, the update and then, in the back
// end, two 64-step restoring divisions and a 32-step square root.
// A word that leaves the count at zero skips the divisions and the root.
// A two-word queue lets the front accept while the back works; a stalled
// result holds the back end. Reset clears the statistics, queue and output.
// ----------------------------------------------------------------------------
module running_error_statistics_core import res_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_kind,
  input  logic signed [SAMPLE_W-1:0] in_error_sample,
  output logic out_valid,
  input  logic out_ready,
  output logic [CNT_W-1:0] out_sample_count,
  output logic [MEAN_W-1:0] out_mean_abs_error,
  output logic [MEAN_W-1:0] out_rms_error
);
  logic q_valid, q_ready;
  cmd_t q_cmd;

  res_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_error_sample,
    .q_valid, .q_ready, .q_cmd);
  res_back #(.COUNT_BITS(COUNT_BITS)) u_back (.clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_sample_count, .out_mean_abs_error, .out_rms_error);
endmodule
